// File: src/dmc_pkg.sv
// shared types and constants for the direct-mapped read cache
package dmc_pkg;

	localparam int ADDR_W = 10;
	localparam int DATA_W = 8;
	localparam int TAG_W = 8;
	localparam int CNT_W = 32;
	localparam int PEN_W = 8;

	localparam logic [PEN_W-1:0] PENALTY_RESET = 8'd10;

	localparam logic CMD_PRELOAD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic load;
		logic check;
		logic fill;
		logic respond;
	} ctl_t;

	typedef struct packed {
		logic hit;
		logic fill_done;
	} stat_t;

endpackage

// File: src/dmc_ctrl.sv
// controller state machine for the direct-mapped read cache
module dmc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          cmd,
	input  dmc_pkg::stat_t st,
	output dmc_pkg::ctl_t  ctl,
	output logic          busy
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_FILL  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		ctl = '0;
		unique case (state_q)
			ST_IDLE: begin
				ctl.load = start;
				if (start && cmd == dmc_pkg::CMD_READ) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				ctl.check = 1'b1;
				if (st.hit) begin
					ctl.respond = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				ctl.fill = 1'b1;
				if (st.fill_done) begin
					ctl.respond = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	a_fill_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL && st.fill_done) |=> state_q == ST_IDLE)
		else $error("controller did not return to idle after fill");

	a_preload_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start && cmd == dmc_pkg::CMD_PRELOAD) |=> state_q == ST_IDLE)
		else $error("preload request left idle");

	a_miss_enters_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && !st.hit) |=> state_q == ST_FILL)
		else $error("miss did not start a fill");

endmodule

// File: src/dmc_datapath.sv
// datapath of the direct-mapped read cache: memories, tag check, fill and counters
module dmc_datapath #(
	parameter int NUM_LINES       = 4,
	parameter int BYTES_PER_BLOCK = 8,
	parameter int MEMORY_BYTES    = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dmc_pkg::ctl_t                       ctl,
	output dmc_pkg::stat_t                      st,
	input  logic                                cmd,
	input  logic [dmc_pkg::ADDR_W-1:0]          address,
	input  logic [dmc_pkg::DATA_W-1:0]          write_data,
	input  logic                                cfg_we,
	input  logic [dmc_pkg::PEN_W-1:0]           cfg_wdata,
	output logic                                done,
	output logic                                hit,
	output logic [dmc_pkg::DATA_W-1:0]          data,
	output logic [dmc_pkg::CNT_W-1:0]           total_time,
	output logic [dmc_pkg::CNT_W-1:0]           miss_count,
	output logic [dmc_pkg::CNT_W-1:0]           access_count
);

	localparam int ADDR_W  = dmc_pkg::ADDR_W;
	localparam int DATA_W  = dmc_pkg::DATA_W;
	localparam int TAG_W   = dmc_pkg::TAG_W;
	localparam int CNT_W   = dmc_pkg::CNT_W;
	localparam int OFS_SH  = $clog2(BYTES_PER_BLOCK);
	localparam int OFS_W   = (OFS_SH > 0) ? OFS_SH : 1;
	localparam int LINE_SH = $clog2(NUM_LINES);
	localparam int LINE_W  = (LINE_SH > 0) ? LINE_SH : 1;
	localparam int LM_W    = LINE_W + OFS_W;
	localparam int MEM_W   = $clog2(MEMORY_BYTES);
	localparam int ISS_W   = $clog2(BYTES_PER_BLOCK + 1);

	logic [DATA_W-1:0] bmem [MEMORY_BYTES];
	logic [DATA_W-1:0] line_mem [1 << LM_W];
	logic [TAG_W-1:0]  tag_mem [1 << LINE_W];

	logic [ADDR_W-1:0]        addr_q;
	logic [TAG_W-1:0]         tag_rd_q;
	logic [DATA_W-1:0]        byte_rd_q;
	logic [NUM_LINES-1:0]     valid_q;
	logic [dmc_pkg::PEN_W-1:0] penalty_q;
	logic [ISS_W-1:0]         issue_q;
	logic                     wr_vld_s1;
	logic [OFS_W-1:0]         wr_idx_s1;
	logic [DATA_W-1:0]        bm_rd_s1;
	logic                     done_q;
	logic                     hit_q;
	logic [DATA_W-1:0]        data_q;
	logic [CNT_W-1:0]         time_q;
	logic [CNT_W-1:0]         miss_q;
	logic [CNT_W-1:0]         acc_q;

	logic [OFS_W-1:0]  word_in;
	logic [LINE_W-1:0] line_in;
	logic [OFS_W-1:0]  word_c;
	logic [LINE_W-1:0] line_c;
	logic [TAG_W-1:0]  tag_c;
	logic              hit_c;
	logic [ADDR_W-1:0] fill_addr;
	logic              issuing;
	logic [CNT_W:0]    time_sum;

	assign word_in = OFS_W'(address & ADDR_W'(BYTES_PER_BLOCK - 1));
	assign line_in = LINE_W'((address >> OFS_SH) & ADDR_W'(NUM_LINES - 1));
	assign word_c  = OFS_W'(addr_q & ADDR_W'(BYTES_PER_BLOCK - 1));
	assign line_c  = LINE_W'((addr_q >> OFS_SH) & ADDR_W'(NUM_LINES - 1));
	assign tag_c   = TAG_W'(addr_q >> (OFS_SH + LINE_SH));
	assign hit_c   = valid_q[line_c] && (tag_rd_q == tag_c);

	assign fill_addr = (addr_q & ~ADDR_W'(BYTES_PER_BLOCK - 1)) | ADDR_W'(issue_q);
	assign issuing   = ctl.fill && (issue_q < ISS_W'(BYTES_PER_BLOCK));

	assign time_sum = {1'b0, time_q} + (CNT_W + 1)'(penalty_q) + (CNT_W + 1)'(1);

	assign st.hit       = hit_c;
	assign st.fill_done = wr_vld_s1 && (wr_idx_s1 == OFS_W'(BYTES_PER_BLOCK - 1));

	// backing memory
	always_ff @(posedge clk) begin
		if (ctl.load && cmd == dmc_pkg::CMD_PRELOAD) begin
			bmem[MEM_W'(address)] <= write_data;
		end
		if (issuing) begin
			bm_rd_s1 <= bmem[MEM_W'(fill_addr)];
		end
	end

	// line data
	always_ff @(posedge clk) begin
		if (wr_vld_s1) begin
			line_mem[{line_c, wr_idx_s1}] <= bm_rd_s1;
		end
		if (ctl.load) begin
			byte_rd_q <= line_mem[{line_in, word_in}];
		end
	end

	// line tags
	always_ff @(posedge clk) begin
		if (ctl.check && !hit_c) begin
			tag_mem[line_c] <= tag_c;
		end
		if (ctl.load) begin
			tag_rd_q <= tag_mem[line_in];
		end
	end

	// request capture and fill pipeline payload
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			addr_q <= address;
		end
		if (issuing) begin
			wr_idx_s1 <= OFS_W'(issue_q);
		end
		if (ctl.check) begin
			hit_q <= hit_c;
			if (hit_c) begin
				data_q <= byte_rd_q;
			end
		end
		if (wr_vld_s1 && wr_idx_s1 == word_c) begin
			data_q <= bm_rd_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			penalty_q <= dmc_pkg::PENALTY_RESET;
			issue_q   <= '0;
			wr_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
			time_q    <= '0;
			miss_q    <= '0;
			acc_q     <= '0;
		end else begin
			done_q    <= ctl.respond;
			wr_vld_s1 <= issuing;
			if (cfg_we) begin
				penalty_q <= cfg_wdata;
			end
			if (ctl.check) begin
				issue_q <= '0;
				if (!(&acc_q)) begin
					acc_q <= acc_q + CNT_W'(1);
				end
				if (hit_c) begin
					if (!(&time_q)) begin
						time_q <= time_q + CNT_W'(1);
					end
				end else begin
					valid_q[line_c] <= 1'b1;
					if (!(&miss_q)) begin
						miss_q <= miss_q + CNT_W'(1);
					end
					time_q <= time_sum[CNT_W] ? '1 : time_sum[CNT_W-1:0];
				end
			end else if (issuing) begin
				issue_q <= issue_q + ISS_W'(1);
			end
		end
	end

	assign done         = done_q;
	assign hit          = hit_q;
	assign data         = data_q;
	assign total_time   = time_q;
	assign miss_count   = miss_q;
	assign access_count = acc_q;

	a_fill_write_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		wr_vld_s1 |-> $past(ctl.fill))
		else $error("line write outside a fill");

	a_miss_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.check && !hit_c) |=> (miss_q != $past(miss_q)) || (&miss_q))
		else $error("miss not counted");

	a_line_valid_after_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.check && !hit_c) |=> valid_q[line_c])
		else $error("line not marked valid after miss");

endmodule

// File: src/direct_mapped_cache_read.sv
// top level of the direct-mapped read cache
// A request is taken when start is high and busy is low. A preload (cmd 0)
// writes one byte of backing memory in the cycle it is taken and yields no
// result. A read (cmd 1) yields one result, marked by done for a single
// cycle; the receiver cannot stall, so it must take hit, data and the three
// counters in that cycle. A hit keeps busy high through the tag check, and
// done follows in the next cycle. A miss keeps busy high through the tag
// check and the refill: the block is refilled one byte per cycle through
// the single read port of the backing memory, each byte passing through a
// read register before it lands in the line. No clearing pass is needed
// after reset. miss_penalty may be written through cfg_we/cfg_wdata while
// the block is idle.
module direct_mapped_cache_read #(
	parameter int NUM_LINES       = 4,
	parameter int BYTES_PER_BLOCK = 8,
	parameter int MEMORY_BYTES    = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         cmd,
	input  logic [dmc_pkg::ADDR_W-1:0]   address,
	input  logic [dmc_pkg::DATA_W-1:0]   write_data,
	input  logic                         cfg_we,
	input  logic [dmc_pkg::PEN_W-1:0]    cfg_wdata,
	output logic                         done,
	output logic                         hit,
	output logic [dmc_pkg::DATA_W-1:0]   data,
	output logic [dmc_pkg::CNT_W-1:0]    total_time,
	output logic [dmc_pkg::CNT_W-1:0]    miss_count,
	output logic [dmc_pkg::CNT_W-1:0]    access_count
);

	dmc_pkg::ctl_t  ctl;
	dmc_pkg::stat_t st;

	dmc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.st     (st),
		.ctl    (ctl),
		.busy   (busy)
	);

	dmc_datapath #(
		.NUM_LINES       (NUM_LINES),
		.BYTES_PER_BLOCK (BYTES_PER_BLOCK),
		.MEMORY_BYTES    (MEMORY_BYTES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.st           (st),
		.cmd          (cmd),
		.address      (address),
		.write_data   (write_data),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.hit          (hit),
		.data         (data),
		.total_time   (total_time),
		.miss_count   (miss_count),
		.access_count (access_count)
	);

endmodule

// File: bench/dmc_checker.sv
`timescale 1ns / 1ps
// checker for the direct-mapped read cache: shadow cache model and result compare
module dmc_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic                         cmd,
	input  logic [dmc_pkg::ADDR_W-1:0]   address,
	input  logic [dmc_pkg::DATA_W-1:0]   write_data,
	input  logic                         cfg_we,
	input  logic [dmc_pkg::PEN_W-1:0]    cfg_wdata,
	input  logic                         done,
	input  logic                         hit,
	input  logic [dmc_pkg::DATA_W-1:0]   data,
	input  logic [dmc_pkg::CNT_W-1:0]    total_time,
	input  logic [dmc_pkg::CNT_W-1:0]    miss_count,
	input  logic [dmc_pkg::CNT_W-1:0]    access_count,
	output int                           errors,
	output int                           outstanding
);
	localparam int ADDR_W = dmc_pkg::ADDR_W;
	localparam int DATA_W = dmc_pkg::DATA_W;
	localparam int TAG_W  = dmc_pkg::TAG_W;
	localparam int CNT_W  = dmc_pkg::CNT_W;
	localparam int PEN_W  = dmc_pkg::PEN_W;

	typedef struct packed {
		logic              hit;
		logic [DATA_W-1:0] data;
		logic [CNT_W-1:0]  total;
		logic [CNT_W-1:0]  misses;
		logic [CNT_W-1:0]  accesses;
	} read_answer_t;

	logic [PEN_W-1:0]  penalty;
	logic [TAG_W-1:0]  tag_store [4];
	logic [3:0]        line_valid;
	logic [DATA_W-1:0] line_store [32];
	logic [DATA_W-1:0] mem_image [1024];
	logic [CNT_W-1:0]  time_acc;
	logic [CNT_W-1:0]  miss_acc;
	logic [CNT_W-1:0]  access_acc;
	read_answer_t      read_answers [$];

	function automatic logic [CNT_W-1:0] sat_sum(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

	function automatic read_answer_t cache_lookup(input logic [ADDR_W-1:0] a);
		logic [1:0]       ln;
		logic [TAG_W-1:0] tg;
		read_answer_t     r;
		int               i;
		ln = a[4:3];
		tg = {3'b000, a[9:5]};
		r.hit = line_valid[ln] && (tag_store[ln] == tg);
		access_acc = sat_sum(access_acc, 1);
		time_acc = sat_sum(time_acc, 1);
		if (!r.hit) begin
			miss_acc = sat_sum(miss_acc, 1);
			time_acc = sat_sum(time_acc, {24'd0, penalty});
			for (i = 0; i < 8; i++)
				line_store[{ln, i[2:0]}] = mem_image[{a[9:3], i[2:0]}];
			tag_store[ln] = tg;
			line_valid[ln] = 1'b1;
		end
		r.data = line_store[{ln, a[2:0]}];
		r.total = time_acc;
		r.misses = miss_acc;
		r.accesses = access_acc;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		read_answer_t want;
		int k;
		if (!arst_n) begin
			penalty = dmc_pkg::PENALTY_RESET;
			line_valid = '0;
			for (k = 0; k < 4; k++)
				tag_store[k[1:0]] = 8'hFF;
			for (k = 0; k < 32; k++)
				line_store[k[4:0]] = '0;
			time_acc = '0;
			miss_acc = '0;
			access_acc = '0;
			read_answers.delete();
		end else begin
			if (done) begin
				if (read_answers.size() == 0) begin
					if (errors < 10)
						$display("unexpected read result: hit %0b data %02h", hit, data);
					errors++;
				end else begin
					want = read_answers.pop_front();
					if (hit !== want.hit || data !== want.data || total_time !== want.total ||
							miss_count !== want.misses || access_count !== want.accesses) begin
						if (errors < 10) begin
							$write("read mismatch (exp/got): hit %0b/%0b data %02h/%02h ",
								want.hit, hit, want.data, data);
							$display("time %0d/%0d misses %0d/%0d accesses %0d/%0d",
								want.total, total_time, want.misses, miss_count,
								want.accesses, access_count);
						end
						errors++;
					end
				end
			end
			if (cfg_we)
				penalty = cfg_wdata;
			if (start && !busy) begin
				if (cmd == dmc_pkg::CMD_PRELOAD)
					mem_image[address] = write_data;
				else
					read_answers.push_back(cache_lookup(address));
			end
		end
		outstanding = read_answers.size();
	end

endmodule

// File: bench/tb_direct_mapped_cache_read.sv
`timescale 1ns / 1ps
// testbench top for the direct-mapped read cache: request stimulus and verdict
module tb_direct_mapped_cache_read;
	localparam int ADDR_W = dmc_pkg::ADDR_W;
	localparam int DATA_W = dmc_pkg::DATA_W;
	localparam int CNT_W  = dmc_pkg::CNT_W;
	localparam int PEN_W  = dmc_pkg::PEN_W;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              cmd;
	logic [ADDR_W-1:0] address;
	logic [DATA_W-1:0] write_data;
	logic              cfg_we;
	logic [PEN_W-1:0]  cfg_wdata;
	logic              done;
	logic              hit;
	logic [DATA_W-1:0] data;
	logic [CNT_W-1:0]  total_time;
	logic [CNT_W-1:0]  miss_count;
	logic [CNT_W-1:0]  access_count;
	int                errors;
	int                outstanding;

	logic [1023:0]     loaded;
	bit   [127:0]      in_ready;
	int                ready_blocks [$];
	int                sent;
	int                last_blk;
	bit                steady;

	direct_mapped_cache_read dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.address      (address),
		.write_data   (write_data),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.hit          (hit),
		.data         (data),
		.total_time   (total_time),
		.miss_count   (miss_count),
		.access_count (access_count)
	);

	dmc_checker watch (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.address      (address),
		.write_data   (write_data),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.done         (done),
		.hit          (hit),
		.data         (data),
		.total_time   (total_time),
		.miss_count   (miss_count),
		.access_count (access_count),
		.errors       (errors),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#6_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic pace();
		int r;
		int g;
		r = $urandom_range(0, 99);
		if (steady || r < 50)
			g = 0;
		else if (r < 90)
			g = $urandom_range(1, 3);
		else
			g = $urandom_range(8, 40);
		repeat (g) @(negedge clk) start <= 1'b0;
	endtask

	task automatic send_request(input logic c, input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] d);
		int b;
		@(negedge clk);
		start <= 1'b1;
		cmd <= c;
		address <= a;
		write_data <= d;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
		if (c == dmc_pkg::CMD_PRELOAD) begin
			loaded[a] = 1'b1;
			b = int'(a[9:3]);
			if (!in_ready[a[9:3]] && &loaded[{a[9:3], 3'b000} +: 8]) begin
				in_ready[a[9:3]] = 1'b1;
				ready_blocks.push_back(b);
			end
		end
		pace();
	endtask

	task automatic load_block(input int b);
		logic [ADDR_W-1:0] a;
		logic [DATA_W-1:0] d;
		int w;
		for (w = 0; w < 8; w++) begin
			a = {b[6:0], w[2:0]};
			d = DATA_W'($urandom);
			send_request(dmc_pkg::CMD_PRELOAD, a, d);
		end
	endtask

	task automatic read_block(input int b);
		logic [ADDR_W-1:0] a;
		logic [DATA_W-1:0] d;
		int w;
		w = $urandom_range(0, 7);
		a = {b[6:0], w[2:0]};
		d = DATA_W'($urandom);
		last_blk = b;
		send_request(dmc_pkg::CMD_READ, a, d);
	endtask

	task automatic drain();
		@(negedge clk) start <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic set_penalty(input logic [PEN_W-1:0] v);
		drain();
		@(negedge clk) begin
			cfg_we <= 1'b1;
			cfg_wdata <= v;
		end
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	task automatic random_phase(input int goal);
		logic [ADDR_W-1:0] a;
		logic [DATA_W-1:0] d;
		int stop;
		int r;
		stop = sent + goal;
		while (sent < stop) begin
			r = $urandom_range(0, 99);
			if (ready_blocks.size() < 3 || r < 8) begin
				load_block($urandom_range(0, 127));
			end else if (r < 18) begin
				a = ADDR_W'($urandom);
				d = DATA_W'($urandom);
				send_request(dmc_pkg::CMD_PRELOAD, a, d);
			end else if (r < 55) begin
				read_block(last_blk);
			end else begin
				read_block(ready_blocks[$urandom_range(0, ready_blocks.size() - 1)]);
			end
		end
	endtask

	initial begin
		logic [DATA_W-1:0] pattern [8];
		int w;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = dmc_pkg::CMD_PRELOAD;
		address = '0;
		write_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		loaded = '0;
		in_ready = '0;
		sent = 0;
		steady = 1'b0;
		last_blk = 0;
		pattern = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7F, 8'hFE};
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// lowest and highest block, both tag extremes, then a stale hit after a preload
		for (w = 0; w < 8; w++)
			send_request(dmc_pkg::CMD_PRELOAD, 10'(w), pattern[w[2:0]]);
		for (w = 0; w < 8; w++)
			send_request(dmc_pkg::CMD_PRELOAD, 10'(1016 + w), ~pattern[w[2:0]]);
		send_request(dmc_pkg::CMD_READ, 10'd0, 8'hFF);
		send_request(dmc_pkg::CMD_READ, 10'd7, 8'h00);
		send_request(dmc_pkg::CMD_READ, 10'd1023, 8'hFF);
		send_request(dmc_pkg::CMD_READ, 10'd1016, 8'h00);
		send_request(dmc_pkg::CMD_PRELOAD, 10'd0, 8'h3C);
		send_request(dmc_pkg::CMD_READ, 10'd0, 8'hC3);

		random_phase(340);
		set_penalty(8'd255);
		random_phase(340);
		set_penalty(8'd0);
		steady = 1'b1;
		random_phase(340);
		steady = 1'b0;
		set_penalty(PEN_W'($urandom_range(1, 254)));
		random_phase(340);
		drain();

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
